### rtl/pulse_sound_channel_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pulse sound channel
// Concurrent assertion shorthands on clk and rst_n of the asserting module.
// ----------------------------------------------------------------------------
`ifndef PULSE_SOUND_CHANNEL_ASSERT_SVH
`define PULSE_SOUND_CHANNEL_ASSERT_SVH

// same-cycle implication, off during reset
`define PSC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pulse sound channel assertion failed");

// next-cycle implication, off during reset
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pulse sound channel assertion failed");

// next-cycle implication, checked through reset
`define PSC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pulse sound channel assertion failed");

`endif

### rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Types, register codes and tables of the pulse sound channel.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam logic       CMD_TICK  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [2:0] REG_LEN_DUTY  = 3'd0;
  localparam logic [2:0] REG_VOLUME    = 3'd1;
  localparam logic [2:0] REG_PERIOD_LO = 3'd2;
  localparam logic [2:0] REG_CONTROL   = 3'd3;
  localparam logic [2:0] REG_MASTER    = 3'd4;

  localparam logic [10:0] PERIOD_MAX    = 11'h7FF;
  localparam logic [7:0]  LENGTH_EXPIRE = 8'd64;
  localparam logic [7:0]  TPS_RESET     = 8'd21;
  localparam logic [13:0] AMPL_MAX      = 14'd6553;

  typedef struct packed {
    logic       divider_bit;
    logic [7:0] write_data;
    logic [2:0] reg_select;
    logic       command;
  } psc_item_t;

  typedef struct packed {
    logic               channel_active;
    logic signed [13:0] sample;
  } psc_result_t;

  function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
    logic [7:0] pat;
    case (sel)
      2'd0:    pat = 8'b0000_0001;
      2'd1:    pat = 8'b1000_0001;
      2'd2:    pat = 8'b1000_0111;
      2'd3:    pat = 8'b0111_1110;
      default: pat = 8'b0000_0001;
    endcase
    return pat;
  endfunction

  // level * 6553 / 15, truncated
  function automatic logic [13:0] amplitude(input logic [3:0] level);
    logic [13:0] mag;
    case (level)
      4'd0:    mag = 14'd0;
      4'd1:    mag = 14'd436;
      4'd2:    mag = 14'd873;
      4'd3:    mag = 14'd1310;
      4'd4:    mag = 14'd1747;
      4'd5:    mag = 14'd2184;
      4'd6:    mag = 14'd2621;
      4'd7:    mag = 14'd3058;
      4'd8:    mag = 14'd3494;
      4'd9:    mag = 14'd3931;
      4'd10:   mag = 14'd4368;
      4'd11:   mag = 14'd4805;
      4'd12:   mag = 14'd5242;
      4'd13:   mag = 14'd5679;
      4'd14:   mag = 14'd6116;
      4'd15:   mag = AMPL_MAX;
      default: mag = 14'd0;
    endcase
    return mag;
  endfunction

endpackage

### rtl/psc_in_reg.sv
// ----------------------------------------------------------------------------
// psc_in_reg
// Input register stage; hands one beat per cycle to the channel core while down_ready is high.
// ----------------------------------------------------------------------------
module psc_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  psc_pkg::psc_item_t  up_item,
  input  logic                down_ready,
  output logic                take,
  output psc_pkg::psc_item_t  item
);
  import psc_pkg::*;

  logic      valid_r;
  psc_item_t item_r;

  assign take     = valid_r && down_ready;
  assign up_ready = !valid_r || down_ready;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= up_item;
    end
  end

endmodule

### rtl/psc_core.sv
// ----------------------------------------------------------------------------
// psc_core
// Channel state: register writes, trigger, period/duty, length and sampling.
// ----------------------------------------------------------------------------
module psc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 take,
  input  psc_pkg::psc_item_t   item,
  output logic                 res_valid,
  output psc_pkg::psc_result_t res
);
  import psc_pkg::*;

  logic [7:0]  tps_r;
  logic [10:0] period_r,     period_nxt;
  logic [2:0]  duty_pos_r,   duty_pos_nxt;
  logic [1:0]  duty_sel_r,   duty_sel_nxt;
  logic [3:0]  vol_level_r,  vol_level_nxt;
  logic        running_r,    running_nxt;
  logic        len_en_r,     len_en_nxt;
  logic [7:0]  len_cnt_r,    len_cnt_nxt;
  logic [2:0]  frame_r,      frame_nxt;
  logic        prev_div_r,   prev_div_nxt;
  logic [7:0]  smp_cnt_r,    smp_cnt_nxt;
  logic [7:0]  len_duty_r,   len_duty_nxt;
  logic [7:0]  volume_r,     volume_nxt;
  logic [7:0]  period_lo_r,  period_lo_nxt;
  logic [7:0]  control_r,    control_nxt;
  logic        master_r,     master_nxt;

  logic        emit;
  logic        act;
  logic        duty_bit;
  logic [7:0]  pattern;
  logic [13:0] mag;

  always_comb begin
    period_nxt    = period_r;
    duty_pos_nxt  = duty_pos_r;
    duty_sel_nxt  = duty_sel_r;
    vol_level_nxt = vol_level_r;
    running_nxt   = running_r;
    len_en_nxt    = len_en_r;
    len_cnt_nxt   = len_cnt_r;
    frame_nxt     = frame_r;
    prev_div_nxt  = prev_div_r;
    smp_cnt_nxt   = smp_cnt_r;
    len_duty_nxt  = len_duty_r;
    volume_nxt    = volume_r;
    period_lo_nxt = period_lo_r;
    control_nxt   = control_r;
    master_nxt    = master_r;
    emit          = 1'b0;

    if (item.command == CMD_WRITE) begin
      case (item.reg_select)
        REG_LEN_DUTY:  len_duty_nxt  = item.write_data;
        REG_VOLUME:    volume_nxt    = item.write_data;
        REG_PERIOD_LO: period_lo_nxt = item.write_data;
        REG_CONTROL: begin
          control_nxt = item.write_data;
          if (item.write_data[7]) begin
            running_nxt   = 1'b1;
            len_en_nxt    = item.write_data[6];
            vol_level_nxt = volume_r[7:4];
            len_cnt_nxt   = {2'b00, len_duty_r[5:0]};
            period_nxt    = {item.write_data[2:0], period_lo_r};
            duty_sel_nxt  = len_duty_r[7:6];
            duty_pos_nxt  = 3'd0;
          end
        end
        REG_MASTER:    master_nxt    = item.write_data[7];
        default: ;
      endcase
    end else begin
      if (period_r == PERIOD_MAX) begin
        duty_pos_nxt = duty_pos_r + 3'd1;
        period_nxt   = {control_r[2:0], period_lo_r};
      end else begin
        period_nxt = period_r + 11'd1;
      end

      if (prev_div_r && !item.divider_bit) begin
        frame_nxt = frame_r + 3'd1;
        if (!frame_nxt[0] && len_en_r) begin
          len_cnt_nxt = len_cnt_r + 8'd1;
          if (len_cnt_nxt == LENGTH_EXPIRE) begin
            running_nxt = 1'b0;
          end
        end
      end
      prev_div_nxt = item.divider_bit;

      if (smp_cnt_r >= tps_r) begin
        emit        = 1'b1;
        smp_cnt_nxt = 8'd0;
      end else begin
        smp_cnt_nxt = smp_cnt_r + 8'd1;
      end
    end
  end

  assign act      = master_r && (volume_r[7:3] != 5'd0) && running_nxt;
  assign pattern  = duty_pattern(duty_sel_r);
  assign duty_bit = pattern[duty_pos_nxt];
  assign mag      = amplitude(vol_level_r);

  always_comb begin
    res.channel_active = act;
    if (!act) begin
      res.sample = 14'sd0;
    end else if (duty_bit) begin
      res.sample = $signed(mag);
    end else begin
      res.sample = $signed(~mag + 14'd1);
    end
  end

  assign res_valid = take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_wr_en) begin
      tps_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= '0;
      duty_pos_r  <= '0;
      duty_sel_r  <= '0;
      vol_level_r <= '0;
      running_r   <= 1'b0;
      len_en_r    <= 1'b0;
      len_cnt_r   <= '0;
      frame_r     <= '0;
      prev_div_r  <= 1'b0;
      smp_cnt_r   <= '0;
      len_duty_r  <= '0;
      volume_r    <= '0;
      period_lo_r <= '0;
      control_r   <= '0;
      master_r    <= 1'b0;
    end else if (take) begin
      period_r    <= period_nxt;
      duty_pos_r  <= duty_pos_nxt;
      duty_sel_r  <= duty_sel_nxt;
      vol_level_r <= vol_level_nxt;
      running_r   <= running_nxt;
      len_en_r    <= len_en_nxt;
      len_cnt_r   <= len_cnt_nxt;
      frame_r     <= frame_nxt;
      prev_div_r  <= prev_div_nxt;
      smp_cnt_r   <= smp_cnt_nxt;
      len_duty_r  <= len_duty_nxt;
      volume_r    <= volume_nxt;
      period_lo_r <= period_lo_nxt;
      control_r   <= control_nxt;
      master_r    <= master_nxt;
    end
  end

endmodule

### rtl/psc_out_skid.sv
// ----------------------------------------------------------------------------
// psc_out_skid
// Output register with one skid entry; lets the core go on under stall until the skid entry fills.
// ----------------------------------------------------------------------------
module psc_out_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  psc_pkg::psc_result_t push_res,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output psc_pkg::psc_result_t out_res
);
  import psc_pkg::*;

  logic        main_valid_r;
  psc_result_t main_res_r;
  logic        skid_valid_r;
  psc_result_t skid_res_r;
  logic        drain;

  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_res_r;
  assign drain     = out_ready || !main_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        main_res_r <= skid_res_r;
      end else if (push) begin
        main_res_r <= push_res;
      end
    end else if (push) begin
      skid_res_r <= push_res;
    end
  end

endmodule

### rtl/pulse_sound_channel.sv
// ----------------------------------------------------------------------------
// pulse_sound_channel
// Square-wave sound channel: register writes and machine ticks in, samples out.
// ----------------------------------------------------------------------------
// Usage:
//   in_  : one beat per machine cycle. in_tuser is the command (0 tick,
//          1 register write); in_tdata carries select, data and divider bit.
//   out_ : one sample beat for each tick on which the sample count reaches
//          ticks_per_sample; writes and other ticks give no beat.
//   cfg_ : cfg_wr_en writes ticks_per_sample, write only, no wait.
// Path: an accepted tick is held in the input register, passes the core
//   logic and its sample is registered in the output register or skid entry.
// Throughput: one beat per cycle while out_ is not stalled, set by the core
//   state update between the input register and the output register.
// Reset: all channel state and registers clear, ticks_per_sample is 21,
//   both channels empty.
// Stall: a blocked out_ beat holds; one more sample is caught by the skid
//   entry, after which in_tready falls once the input register is full.
// ----------------------------------------------------------------------------
module pulse_sound_channel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // reg_select[2:0], write_data[10:3], divider_bit[11], 0
  input  logic        in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // sample[13:0], channel_active[14], 0
);
  import psc_pkg::*;

  psc_item_t   up_item;
  psc_item_t   item;
  psc_result_t res;
  psc_result_t out_res;
  logic        take;
  logic        res_valid;
  logic        buf_ready;

  assign up_item.command     = in_tuser;
  assign up_item.reg_select  = in_tdata[2:0];
  assign up_item.write_data  = in_tdata[10:3];
  assign up_item.divider_bit = in_tdata[11];

  psc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .up_item    (up_item),
    .down_ready (buf_ready),
    .take       (take),
    .item       (item)
  );

  psc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .take        (take),
    .item        (item),
    .res_valid   (res_valid),
    .res         (res)
  );

  psc_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .ready     (buf_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.channel_active, out_res.sample};

endmodule

### rtl/psc_checker.sv
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks of the pulse sound channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "pulse_sound_channel_assert.svh"

module psc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  import psc_pkg::*;

  localparam logic signed [13:0] SMP_MAX = AMPL_MAX;

  logic signed [13:0] smp;

  assign smp = out_tdata[13:0];

  `PSC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  `PSC_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid && in_tready)

  `PSC_ASSERT_SAME(a_silent_zero, out_tvalid && !out_tdata[14], out_tdata[13:0] == 14'd0)

  `PSC_ASSERT_SAME(a_sample_range, out_tvalid, (smp <= SMP_MAX) && (smp >= -SMP_MAX) && !out_tdata[15])

endmodule

bind pulse_sound_channel psc_checker u_psc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/pulse_sound_channel_tb.sv
// ----------------------------------------------------------------------------
// pulse_sound_channel_tb
// Drives register writes and machine ticks into the pulse sound channel and
// checks every sample beat against a cycle-free model of the channel kept in
// the bench. A short directed part covers trigger, duty, DAC and master off,
// unused selects and length expiry. Random tone bursts with noise follow at
// several ticks_per_sample settings, with both sides stalling in turn.
// ----------------------------------------------------------------------------
module pulse_sound_channel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_SHOWN = 10;
  // duty waves, pattern select picks the byte, position picks the bit
  localparam logic [31:0] DUTY_WAVES = {8'h7E, 8'h87, 8'h81, 8'h01};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;   // reg_select[2:0], write_data[10:3], divider_bit[11], 0
  logic        in_tuser = 1'b0;    // command[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // sample[13:0], channel_active[14], 0

  pulse_sound_channel DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #1 clk = ~clk;

  // channel model state
  logic [7:0]  tps_q;
  logic [10:0] period_cnt;
  logic [2:0]  duty_pos;
  logic [1:0]  duty_sel;
  logic [3:0]  level;
  logic        running;
  logic        len_enable;
  logic [7:0]  len_count;
  logic [2:0]  frame;
  logic        prev_div;
  logic [7:0]  sample_cnt;
  logic [7:0]  len_duty_q;
  logic [7:0]  volume_q;
  logic [7:0]  period_lo_q;
  logic [7:0]  control_q;
  logic        master_on;

  psc_result_t expected_samples[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          tx_idle_pct = 9;
  int          rx_idle_pct = 70;
  int          quiet_cycles = 0;

  initial begin
    tps_q = TPS_RESET;
    period_cnt = '0;
    duty_pos = '0;
    duty_sel = '0;
    level = '0;
    running = 1'b0;
    len_enable = 1'b0;
    len_count = '0;
    frame = '0;
    prev_div = 1'b0;
    sample_cnt = '0;
    len_duty_q = '0;
    volume_q = '0;
    period_lo_q = '0;
    control_q = '0;
    master_on = 1'b0;
  end

  task automatic apply_channel_item(input psc_item_t it);
    logic [13:0] mag;
    psc_result_t r;
    if (it.command == CMD_WRITE) begin
      case (it.reg_select)
        REG_LEN_DUTY:  len_duty_q = it.write_data;
        REG_VOLUME:    volume_q = it.write_data;
        REG_PERIOD_LO: period_lo_q = it.write_data;
        REG_CONTROL: begin
          control_q = it.write_data;
          if (it.write_data[7]) begin
            running = 1'b1;
            len_enable = it.write_data[6];
            level = volume_q[7:4];
            len_count = {2'b00, len_duty_q[5:0]};
            period_cnt = {control_q[2:0], period_lo_q};
            duty_sel = len_duty_q[7:6];
            duty_pos = '0;
          end
        end
        REG_MASTER:    master_on = it.write_data[7];
        default: ;
      endcase
    end else begin
      if (period_cnt == PERIOD_MAX) begin
        duty_pos = duty_pos + 3'd1;
        period_cnt = {control_q[2:0], period_lo_q};
      end else begin
        period_cnt = period_cnt + 11'd1;
      end
      if (prev_div && !it.divider_bit) begin
        frame = frame + 3'd1;
        if (!frame[0] && len_enable) begin
          len_count = len_count + 8'd1;
          if (len_count == LENGTH_EXPIRE) running = 1'b0;
        end
      end
      prev_div = it.divider_bit;
      if (sample_cnt >= tps_q) begin
        sample_cnt = '0;
        r.channel_active = master_on && (volume_q[7:3] != 5'd0) && running;
        r.sample = '0;
        if (r.channel_active) begin
          mag = 14'((int'(level) * int'(AMPL_MAX)) / 15);
          r.sample = DUTY_WAVES[{duty_sel, duty_pos}] ? mag : -mag;
        end
        expected_samples.push_back(r);
      end else begin
        sample_cnt = sample_cnt + 8'd1;
      end
    end
  endtask

  task automatic send_item(input logic cmd, input logic [2:0] sel, input logic [7:0] data,
                           input logic div);
    psc_item_t it;
    it.command = cmd;
    it.reg_select = sel;
    it.write_data = data;
    it.divider_bit = div;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, div, data, sel};
    in_tuser <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    apply_channel_item(it);
  endtask

  task automatic write_reg(input logic [2:0] sel, input logic [7:0] data);
    send_item(CMD_WRITE, sel, data, 1'b0);
  endtask

  task automatic tick(input logic div);
    send_item(CMD_TICK, REG_LEN_DUTY, 8'd0, div);
  endtask

  task automatic drain_channel();
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks_per_sample(input logic [7:0] value);
    drain_channel();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tps_q = value;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // sample beat checker and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("unexpected sample beat: sample %0d active %0b",
                     $signed(out_tdata[13:0]), out_tdata[14]);
        end else begin
          psc_result_t exp_r;
          exp_r = expected_samples.pop_front();
          if (out_tdata[13:0] !== exp_r.sample || out_tdata[14] !== exp_r.channel_active) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("sample mismatch: expected sample %0d active %0b, got sample %0d active %0b",
                       exp_r.sample, exp_r.channel_active,
                       $signed(out_tdata[13:0]), out_tdata[14]);
          end
        end
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("pulse_sound_channel_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_silent_channel();
    tick(1'b1);
    tick(1'b0);
  endtask

  task automatic test_unused_selects();
    for (int s = REG_MASTER + 1; s < 8; s++) write_reg(3'(s), 8'hFF);
  endtask

  task automatic test_trigger_full_scale();
    write_reg(REG_LEN_DUTY, 8'hFF);
    write_reg(REG_VOLUME, 8'hF8);
    write_reg(REG_PERIOD_LO, 8'hFF);
    write_reg(REG_MASTER, 8'h80);
    write_reg(REG_CONTROL, 8'h87);
    repeat (3) tick(1'b0);
  endtask

  task automatic test_control_without_trigger();
    write_reg(REG_CONTROL, 8'h40);
    tick(1'b0);
  endtask

  task automatic test_dac_and_master_off();
    write_reg(REG_VOLUME, 8'h07);
    tick(1'b0);
    write_reg(REG_VOLUME, 8'h08);
    write_reg(REG_MASTER, 8'h00);
    tick(1'b0);
    write_reg(REG_MASTER, 8'h80);
  endtask

  task automatic test_length_expiry();
    write_reg(REG_LEN_DUTY, 8'h3F);
    write_reg(REG_CONTROL, 8'hC7);
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    tick(1'b0);
  endtask

  task automatic send_noise();
    send_item(1'($urandom), 3'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // setup writes, trigger, then a run of ticks with a toggling divider
  task automatic run_tone_burst();
    logic [7:0] len_duty;
    logic [7:0] vol;
    logic [7:0] plo;
    logic [7:0] ctrl;
    logic [7:0] mst;
    int         n_ticks;
    int         half;
    logic       div;
    len_duty[7:6] = 2'($urandom);
    len_duty[5:0] = $urandom_range(1) ? 6'($urandom_range(63, 48)) : 6'($urandom);
    vol = 8'($urandom);
    if ($urandom_range(19) == 0) vol[7:3] = 5'd0;
    plo = $urandom_range(1) ? 8'($urandom_range(255, 240)) : 8'($urandom);
    mst = 8'($urandom);
    mst[7] = ($urandom_range(9) != 0);
    ctrl = 8'($urandom);
    ctrl[7] = 1'b1;
    if ($urandom_range(3) != 0) ctrl[2:0] = 3'd7;
    write_reg(REG_LEN_DUTY, len_duty);
    write_reg(REG_VOLUME, vol);
    write_reg(REG_PERIOD_LO, plo);
    write_reg(REG_MASTER, mst);
    write_reg(REG_CONTROL, ctrl);
    n_ticks = $urandom_range(60, 10);
    half = $urandom_range(4, 1);
    div = 1'($urandom);
    for (int i = 0; i < n_ticks; i++) begin
      if (i % half == 0) div = ~div;
      if ($urandom_range(19) == 0) send_noise();
      tick(div);
    end
  endtask

  task automatic test_random_traffic(input logic [7:0] tps, input int n_items);
    int stop_at;
    write_ticks_per_sample(tps);
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 80) run_tone_burst();
      else repeat ($urandom_range(8, 1)) send_noise();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idle(9, 70);
    write_ticks_per_sample(8'd0);
    test_silent_channel();
    test_unused_selects();
    test_trigger_full_scale();
    test_control_without_trigger();
    test_dac_and_master_off();
    test_length_expiry();

    test_random_traffic(8'd1, 200);
    test_random_traffic(8'd255, 250);
    set_idle(70, 9);
    test_random_traffic(8'($urandom_range(12, 2)), 200);
    test_random_traffic(8'd0, 150);
    set_idle(0, 0);
    test_random_traffic(8'($urandom_range(30, 1)), 250);
    test_random_traffic(8'd3, 200);

    drain_channel();
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("pulse_sound_channel_tb: clean");
    end else begin
      $display("pulse_sound_channel_tb: errors");
    end
    $finish;
  end

endmodule
